### sv/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types and constants of the quadratic real root solver.
// ----------------------------------------------------------------------------
`default_nettype none
package qrs_pkg;
   localparam int CoefWidthDefault = 16;
   localparam int FracBitsDefault  = 16;
   localparam int RootWidth        = 33;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_ONE  = 2'd1,
      KIND_TWO  = 2'd2,
      KIND_ALL  = 2'd3
   } kind_type;
endpackage
`default_nettype wire

### sv/quadratic_real_root_solver.sv
// ----------------------------------------------------------------------------
// quadratic_real_root_solver
// Real roots of a*x^2+b*x+c=0 in signed fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// The block takes one coefficient triple per clock and returns, in order, the
// kind of solution set and the real roots with FRAC_BITS fraction bits, the
// smaller root first. Throughput is one transaction per cycle. With the
// default widths the pipeline is made of two front stages (products,
// then discriminant and case decision), a square root pipeline of an input
// register plus one stage per root bit (35), one stage forming the signed
// numerators and divisor, two divider pipelines side by side with an input
// register plus one stage per quotient bit (36), and the output register,
// which also applies sign, ordering and saturation. The whole pipeline
// advances together and holds when the output register is full and not
// taken; ready therefore stays high while the output is free.
`default_nettype none
module quadratic_real_root_solver import qrs_pkg::*; #(
   parameter int COEF_WIDTH = CoefWidthDefault,
   parameter int FRAC_BITS  = FracBitsDefault
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic signed [COEF_WIDTH-1:0]  req_coef_a,
   input  wire logic signed [COEF_WIDTH-1:0]  req_coef_b,
   input  wire logic signed [COEF_WIDTH-1:0]  req_coef_c,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [1:0]                         rsp_kind,
   output logic signed [RootWidth-1:0]        rsp_root_low,
   output logic signed [RootWidth-1:0]        rsp_root_high
);
   localparam int CW    = COEF_WIDTH;
   localparam int PW    = 2 * CW;           // magnitude product width
   localparam int DW    = PW + 3;           // discriminant width
   localparam int SqIn  = ((DW + 2 * FRAC_BITS + 1) / 2) * 2;
   localparam int RtW   = SqIn / 2;          // sqrt result width
   localparam int NumW  = (RtW > CW + FRAC_BITS ? RtW : CW + FRAC_BITS) + 1;
   localparam int DenW  = CW + 1;
   localparam int SideW = 4;                 // kind, two sign flags

   logic enable;

   // Hold the pipeline only while a result waits in the output register
   assign enable    = !rsp_valid || rsp_ready;
   assign req_ready = enable;

   // ---- stage 1: magnitudes and products ----
   logic            s1_valid_ff;
   logic [PW-1:0]   s1_b2_ff, s1_ac_ff;
   logic            s1_same_ff, s1_azero_ff, s1_bzero_ff, s1_czero_ff;
   logic signed [CW-1:0] s1_a_ff, s1_b_ff, s1_c_ff;
   logic [CW-1:0]   ma_in, mb_in, mc_in;

   always_comb begin
      ma_in = req_coef_a[CW-1] ? CW'(-req_coef_a) : req_coef_a;
      mb_in = req_coef_b[CW-1] ? CW'(-req_coef_b) : req_coef_b;
      mc_in = req_coef_c[CW-1] ? CW'(-req_coef_c) : req_coef_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (enable) begin
         s1_valid_ff <= req_valid;
      end
      if (enable) begin
         s1_b2_ff    <= mb_in * mb_in;
         s1_ac_ff    <= ma_in * mc_in;
         s1_same_ff  <= req_coef_a[CW-1] == req_coef_c[CW-1];
         s1_azero_ff <= req_coef_a == '0;
         s1_bzero_ff <= req_coef_b == '0;
         s1_czero_ff <= req_coef_c == '0;
         s1_a_ff     <= req_coef_a;
         s1_b_ff     <= req_coef_b;
         s1_c_ff     <= req_coef_c;
      end
   end

   // ---- stage 2: discriminant and case decision ----
   logic            s2_valid_ff;
   logic [DW-1:0]   s2_disc_ff;
   logic [1:0]      s2_kind_ff;
   logic            s2_lin_ff;
   logic signed [CW-1:0] s2_a_ff, s2_b_ff, s2_c_ff;
   logic [DW-1:0]   ac4_in, b2_in, disc_in;
   logic            neg_in;
   logic [1:0]      kind_in;

   always_comb begin
      ac4_in = {1'b0, s1_ac_ff, 2'b00};
      b2_in  = DW'(s1_b2_ff);
      neg_in = 1'b0;
      if (!s1_czero_ff && s1_same_ff) begin
         if (ac4_in <= b2_in) begin
            disc_in = b2_in - ac4_in;
         end else begin
            disc_in = b2_in;
            neg_in  = 1'b1;
         end
      end else begin
         disc_in = b2_in + ac4_in;
      end
      if (s1_azero_ff) begin
         if (s1_bzero_ff) kind_in = s1_czero_ff ? KIND_ALL : KIND_NONE;
         else             kind_in = KIND_ONE;
      end else if (neg_in) begin
         kind_in = KIND_NONE;
      end else if (disc_in == '0) begin
         kind_in = KIND_ONE;
      end else begin
         kind_in = KIND_TWO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (enable) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (enable) begin
         s2_disc_ff <= (kind_in == KIND_TWO) ? disc_in : '0;
         s2_kind_ff <= kind_in;
         s2_lin_ff  <= s1_azero_ff;
         s2_a_ff    <= s1_a_ff;
         s2_b_ff    <= s1_b_ff;
         s2_c_ff    <= s1_c_ff;
      end
   end

   // ---- square root of D * 2^(2F); coefficients ride in a side pipe ----
   localparam int CoefSide = 3 * CW + 3;
   logic [SqIn-1:0]      sq_op_in;
   logic                 sq_valid;
   logic [RtW-1:0]       sq_root;
   logic [CoefSide-1:0]  sq_side;

   assign sq_op_in = SqIn'({s2_disc_ff, {(2 * FRAC_BITS){1'b0}}});

   qrs_sqrt #(.OpWidth(SqIn), .SideWidth(CoefSide)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (s2_valid_ff),
      .in_op     (sq_op_in),
      .in_side   ({s2_kind_ff, s2_lin_ff, s2_a_ff, s2_b_ff, s2_c_ff}),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // ---- stage 3: signed numerators and divisor ----
   logic [1:0]           q_kind;
   logic                 q_lin;
   logic signed [CW-1:0] q_a, q_b, q_c;
   assign {q_kind, q_lin, q_a, q_b, q_c} = sq_side;

   logic signed [NumW:0] nb_in, np_in, nq_in;
   logic signed [DenW:0] den_in;

   logic                 s3_valid_ff;
   logic [NumW-1:0]      s3_mp_ff, s3_mq_ff;
   logic [DenW-1:0]      s3_den_ff;
   logic [SideW-1:0]     s3_side_ff;

   always_comb begin
      if (q_lin) begin
         nb_in  = -((NumW+1)'(q_c) <<< FRAC_BITS);
         den_in = (DenW+1)'(q_b);
      end else begin
         nb_in  = -((NumW+1)'(q_b) <<< FRAC_BITS);
         den_in = (DenW+1)'(q_a) <<< 1;
      end
      np_in = nb_in + $signed({1'b0, (NumW)'(sq_root)});
      nq_in = nb_in - $signed({1'b0, (NumW)'(sq_root)});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (enable) begin
         s3_valid_ff <= sq_valid;
      end
      if (enable) begin
         s3_mp_ff  <= np_in[NumW] ? NumW'(-np_in) : NumW'(np_in);
         s3_mq_ff  <= nq_in[NumW] ? NumW'(-nq_in) : NumW'(nq_in);
         s3_den_ff <= den_in[DenW] ? DenW'(-den_in) : DenW'(den_in);
         s3_side_ff <= {q_kind, np_in[NumW] ^ den_in[DenW], nq_in[NumW] ^ den_in[DenW]};
      end
   end

   // ---- two dividers side by side ----
   logic            dp_valid, dq_valid;
   logic [NumW-1:0] dp_quot, dq_quot;
   logic [SideW-1:0] dp_side, dq_side;

   qrs_div #(.NumWidth(NumW), .DenWidth(DenW), .SideWidth(SideW)) u_div_p (
      .clock(clock), .reset(reset), .enable(enable),
      .in_valid(s3_valid_ff), .in_num(s3_mp_ff), .in_den(s3_den_ff),
      .in_side(s3_side_ff),
      .out_valid(dp_valid), .out_quot(dp_quot), .out_side(dp_side)
   );

   qrs_div #(.NumWidth(NumW), .DenWidth(DenW), .SideWidth(SideW)) u_div_q (
      .clock(clock), .reset(reset), .enable(enable),
      .in_valid(s3_valid_ff), .in_num(s3_mq_ff), .in_den(s3_den_ff),
      .in_side(s3_side_ff),
      .out_valid(dq_valid), .out_quot(dq_quot), .out_side(dq_side)
   );

   // ---- final stage: sign, order, saturate ----
   localparam logic signed [NumW:0] RootMax = (NumW+1)'((64'sd1 <<< (RootWidth-1)) - 1);
   localparam logic signed [NumW:0] RootMin = (NumW+1)'(-(64'sd1 <<< (RootWidth-1)));

   logic signed [NumW:0] p_in, q_in, lo_in, hi_in;
   logic [1:0]           f_kind;

   function automatic logic signed [RootWidth-1:0] sat_root(input logic signed [NumW:0] v);
      if (v > RootMax)      sat_root = RootWidth'(RootMax);
      else if (v < RootMin) sat_root = RootWidth'(RootMin);
      else                  sat_root = RootWidth'(v);
   endfunction

   always_comb begin
      f_kind = dp_side[3:2];
      p_in = dp_side[1] ? -$signed({1'b0, dp_quot}) : $signed({1'b0, dp_quot});
      q_in = dq_side[0] ? -$signed({1'b0, dq_quot}) : $signed({1'b0, dq_quot});
      lo_in = (p_in < q_in) ? p_in : q_in;
      hi_in = (p_in < q_in) ? q_in : p_in;
      if (f_kind == KIND_NONE || f_kind == KIND_ALL) begin
         lo_in = '0;
         hi_in = '0;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (enable) begin
         rsp_valid <= dp_valid & dq_valid;
      end
      if (enable) begin
         rsp_kind      <= f_kind;
         rsp_root_low  <= sat_root(lo_in);
         rsp_root_high <= sat_root(hi_in);
      end
   end
endmodule
`default_nettype wire

### sv/qrs_sqrt.sv
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined restoring square root, one result bit per stage, with a sideband
// that travels alongside the operand through every stage.
// ----------------------------------------------------------------------------
`default_nettype none
module qrs_sqrt import qrs_pkg::*; #(
   parameter int OpWidth   = 64,
   parameter int SideWidth = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   enable,
   input  wire logic                   in_valid,
   input  wire logic [OpWidth-1:0]     in_op,
   input  wire logic [SideWidth-1:0]   in_side,
   output logic                        out_valid,
   output logic [OpWidth/2-1:0]        out_root,
   output logic [SideWidth-1:0]        out_side
);
   localparam int Steps = OpWidth / 2;
   localparam int RemW  = OpWidth / 2 + 2;

   logic                           valid_ff [Steps+1];
   logic [OpWidth-1:0]             op_ff   [Steps+1];
   logic [RemW-1:0]                rem_ff  [Steps+1];
   logic [Steps-1:0]               root_ff [Steps+1];
   logic [SideWidth-1:0]           side_ff [Steps+1];

   // Load the first stage
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (enable) begin
         valid_ff[0] <= in_valid;
      end
      if (enable) begin
         op_ff[0]   <= in_op;
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         side_ff[0] <= in_side;
      end
   end

   // One root bit per stage
   for (genvar i = 0; i < Steps; i++) begin : g_step
      logic [RemW-1:0]  trial_in;
      logic [RemW-1:0]  cand_in;
      logic [RemW:0]    diff_in;
      always_comb begin
         trial_in = {rem_ff[i][RemW-3:0], op_ff[i][OpWidth-1 -: 2]};
         cand_in  = {root_ff[i], 2'b01};
         diff_in  = {1'b0, trial_in} - {1'b0, cand_in};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else if (enable) begin
            valid_ff[i+1] <= valid_ff[i];
         end
         if (enable) begin
            op_ff[i+1]   <= {op_ff[i][OpWidth-3:0], 2'b00};
            side_ff[i+1] <= side_ff[i];
            if (!diff_in[RemW]) begin
               rem_ff[i+1]  <= diff_in[RemW-1:0];
               root_ff[i+1] <= {root_ff[i][Steps-2:0], 1'b1};
            end else begin
               rem_ff[i+1]  <= trial_in;
               root_ff[i+1] <= {root_ff[i][Steps-2:0], 1'b0};
            end
         end
      end
   end

   assign out_valid = valid_ff[Steps];
   assign out_root  = root_ff[Steps];
   assign out_side  = side_ff[Steps];
endmodule
`default_nettype wire

### sv/qrs_div.sv
// ----------------------------------------------------------------------------
// qrs_div
// Pipelined restoring divider on magnitudes, one quotient bit per stage,
// with a sideband carried along.
// ----------------------------------------------------------------------------
`default_nettype none
module qrs_div import qrs_pkg::*; #(
   parameter int NumWidth  = 64,
   parameter int DenWidth  = 34,
   parameter int SideWidth = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  enable,
   input  wire logic                  in_valid,
   input  wire logic [NumWidth-1:0]   in_num,
   input  wire logic [DenWidth-1:0]   in_den,
   input  wire logic [SideWidth-1:0]  in_side,
   output logic                       out_valid,
   output logic [NumWidth-1:0]        out_quot,
   output logic [SideWidth-1:0]       out_side
);
   logic                    valid_ff [NumWidth+1];
   logic [NumWidth-1:0]     num_ff  [NumWidth+1];
   logic [DenWidth-1:0]     rem_ff  [NumWidth+1];
   logic [DenWidth-1:0]     den_ff  [NumWidth+1];
   logic [SideWidth-1:0]    side_ff [NumWidth+1];

   // Load the first stage; the quotient shifts into the numerator register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (enable) begin
         valid_ff[0] <= in_valid;
      end
      if (enable) begin
         num_ff[0]  <= in_num;
         rem_ff[0]  <= '0;
         den_ff[0]  <= in_den;
         side_ff[0] <= in_side;
      end
   end

   // One quotient bit per stage
   for (genvar i = 0; i < NumWidth; i++) begin : g_step
      logic [DenWidth:0] trial_in;
      logic [DenWidth:0] diff_in;
      always_comb begin
         trial_in = {rem_ff[i], num_ff[i][NumWidth-1]};
         diff_in  = trial_in - {1'b0, den_ff[i]};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else if (enable) begin
            valid_ff[i+1] <= valid_ff[i];
         end
         if (enable) begin
            den_ff[i+1]  <= den_ff[i];
            side_ff[i+1] <= side_ff[i];
            if (trial_in >= {1'b0, den_ff[i]}) begin
               rem_ff[i+1] <= diff_in[DenWidth-1:0];
               num_ff[i+1] <= {num_ff[i][NumWidth-2:0], 1'b1};
            end else begin
               rem_ff[i+1] <= trial_in[DenWidth-1:0];
               num_ff[i+1] <= {num_ff[i][NumWidth-2:0], 1'b0};
            end
         end
      end
   end

   assign out_valid = valid_ff[NumWidth];
   assign out_quot  = num_ff[NumWidth];
   assign out_side  = side_ff[NumWidth];
endmodule
`default_nettype wire

### sv/qrs_checker.sv
// ----------------------------------------------------------------------------
// qrs_checker
// Port-level checks of the quadratic real root solver.
// ----------------------------------------------------------------------------
`default_nettype none
module qrs_checker import qrs_pkg::*; (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [1:0]                    rsp_kind,
   input wire logic signed [RootWidth-1:0]   rsp_root_low,
   input wire logic signed [RootWidth-1:0]   rsp_root_high
);
   // Keep a stalled result in place
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_root_low))
      else $error("result changed while stalled");

   // Order the roots
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_root_low <= rsp_root_high)
      else $error("roots out of order");

   // Zero roots when no single root set exists
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_NONE || rsp_kind == KIND_ALL)
      |-> rsp_root_low == '0 && rsp_root_high == '0)
      else $error("roots not cleared");

   // Equal roots for a single root
   a_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_ONE |-> rsp_root_low == rsp_root_high)
      else $error("single root mismatch");

   // Accept whenever the output is free
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("stalled with empty output");
endmodule

bind quadratic_real_root_solver qrs_checker u_qrs_checker (.*);
`default_nettype wire
